### hdl/sspk_pkg.sv
// shared types, constants and the hex digit lookup for the septet packer
// no dependencies
package sspk_pkg;

  localparam int QDEPTH = 4;

  localparam int CHAR_W  = 8;
  localparam int OCTET_W = 8;
  localparam int ASCII_W = 7;
  localparam int SEPT_W  = 7;
  localparam int CNT_W   = 3;
  localparam int OUT_W   = 24;

  localparam logic MODE_SEPTET = 1'b0;
  localparam logic MODE_OCTET  = 1'b1;

  localparam logic [ASCII_W-1:0] HEX_DIGITS [16] = '{
    7'd48, 7'd49, 7'd50, 7'd51, 7'd52, 7'd53, 7'd54, 7'd55,
    7'd56, 7'd57, 7'd65, 7'd66, 7'd67, 7'd68, 7'd69, 7'd70
  };

  // up to two octets caused by one character; the second is always final
  typedef struct packed {
    logic [OCTET_W-1:0] oct0;
    logic               fin0;
    logic               two;
    logic [OCTET_W-1:0] oct1;
  } sspk_job_t;

  function automatic logic [ASCII_W-1:0] hex_digit(input logic [3:0] nib);
    hex_digit = HEX_DIGITS[nib];
  endfunction

endpackage

### hdl/sspk_front.sv
// front end: mode register, septet packing state, job generation
// depends on sspk_pkg
module sspk_front
  import sspk_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [CHAR_W-1:0] in_tdata,
  input  logic              in_tlast,
  input  logic              q_full,
  output logic              push,
  output sspk_job_t         push_job
);

  logic              mode_r;
  logic [SEPT_W-1:0] carry_r, carry_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              fire;
  logic [14:0]       acc;
  logic [3:0]        n7;
  logic [3:0]        n_rem;
  logic [SEPT_W-1:0] rem;
  logic              full8;

  assign in_tready = !q_full;
  assign fire      = in_tvalid && in_tready;

  always_comb begin
    acc   = {8'd0, carry_r} | ({8'd0, in_tdata[SEPT_W-1:0]} << cnt_r);
    n7    = {1'b0, cnt_r} + 4'd7;
    full8 = n7[3];
    if (full8) begin
      rem   = acc[14:8];
      n_rem = n7 - 4'd8;
    end else begin
      rem   = acc[6:0];
      n_rem = n7;
    end
    push_job  = '0;
    push      = 1'b0;
    carry_nxt = carry_r;
    cnt_nxt   = cnt_r;
    if (mode_r == MODE_OCTET) begin
      push_job.oct0 = in_tdata;
      push_job.fin0 = in_tlast;
      push          = fire;
      carry_nxt     = '0;
      cnt_nxt       = '0;
    end else begin
      if (full8) begin
        push_job.oct0 = acc[7:0];
        push_job.fin0 = in_tlast && (n7 == 4'd8);
        push_job.two  = in_tlast && (n_rem != 4'd0);
        push_job.oct1 = {1'b0, rem};
        push          = fire;
      end else begin
        push_job.oct0 = {1'b0, rem};
        push_job.fin0 = 1'b1;
        push          = fire && in_tlast;
      end
      if (in_tlast) begin
        carry_nxt = '0;
        cnt_nxt   = '0;
      end else begin
        carry_nxt = rem;
        cnt_nxt   = n_rem[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_SEPTET;
      carry_r <= '0;
      cnt_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (fire) begin
        carry_r <= carry_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_tlast) |=> (cnt_r == '0 && carry_r == '0))
    else $error("carry state not cleared after final character");

endmodule

### hdl/sspk_queue.sv
// small job queue between front and back ends
// depends on sspk_pkg
module sspk_queue
  import sspk_pkg::*;
#(
  parameter int DEPTH = QDEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  sspk_job_t push_job,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output sspk_job_t head_job
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  sspk_job_t       mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_pop;

  assign full       = (count_r == FULL_CNT);
  assign head_valid = (count_r != '0);
  assign head_job   = mem[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("job queue overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("job queue count out of range");

endmodule

### hdl/sspk_back.sv
// back end: expands jobs into octets, adds hex digits, holds the output register
// depends on sspk_pkg
module sspk_back
  import sspk_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  sspk_job_t        head_job,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,
  output logic             out_tlast
);

  logic               out_valid_r;
  logic [OUT_W-1:0]   out_data_r;
  logic               out_last_r;
  logic               sec_valid_r;
  logic [OCTET_W-1:0] sec_oct_r;
  logic               load;
  logic               src_valid;
  logic [OCTET_W-1:0] src_oct;
  logic               src_last;

  assign load = !out_valid_r || out_tready;
  assign pop  = load && !sec_valid_r && head_valid;

  always_comb begin
    if (sec_valid_r) begin
      src_valid = 1'b1;
      src_oct   = sec_oct_r;
      src_last  = 1'b1;
    end else begin
      src_valid = head_valid;
      src_oct   = head_job.oct0;
      src_last  = head_job.fin0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sec_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= src_valid;
      if (sec_valid_r) begin
        sec_valid_r <= 1'b0;
      end else if (head_valid) begin
        sec_valid_r <= head_job.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= {2'b00, hex_digit(src_oct[3:0]), hex_digit(src_oct[7:4]), src_oct};
      out_last_r <= src_last;
      if (pop) begin
        sec_oct_r <= head_job.oct1;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_sec_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    sec_valid_r |-> (out_valid_r && !out_last_r))
    else $error("second octet pending without a non-final first octet");

  a_no_pop_with_sec: assert property (@(posedge clk) disable iff (!rst_n)
    sec_valid_r |-> !pop)
    else $error("queue popped while second octet pending");

endmodule

### hdl/sms_septet_packer_hex_unit.sv
// top level of the sms septet packer with hex output
// depends on sspk_pkg, sspk_front, sspk_queue, sspk_back
//
// channel  | dir | data                                           | marker
// in_      | in  | tdata[7:0] character                           | tlast final_char
// out_     | out | tdata[7:0] octet, [14:8] hex_high, [21:15] hex_low | tlast final_octet
// cfg_     | in  | wr_data packing_mode (0 septets, 1 octets)     | wr_en
//
// one character accepted per cycle while the queue has room; a final character that
// flushes two octets sends them in turn through the single output register, and the
// job queue holds later jobs meanwhile; out_tvalid comes from the output register
// rst_n is synchronous: clears mode, carry state, queue and output valid
// either side may stall independently; the input stalls only when the queue is full
module sms_septet_packer_hex_unit
  import sspk_pkg::*;
#(
  parameter int QUEUE_DEPTH = QDEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,   // packing_mode
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [CHAR_W-1:0] in_tdata,      // character
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,     // octet, hex_high, hex_low, 2 zero bits
  output logic              out_tlast
);

  logic      q_full;
  logic      push;
  sspk_job_t push_job;
  logic      pop;
  logic      head_valid;
  sspk_job_t head_job;

  sspk_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .q_full      (q_full),
    .push        (push),
    .push_job    (push_job)
  );

  sspk_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  sspk_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
